>>> rtl/sha1bsd_pkg.sv
// Shared types and constants for the byte-stream SHA-1 digest engine.
package sha1bsd_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned HASH_WORDS  = 5;
  localparam int unsigned COUNT_W     = 61;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_ADD  = 7'd80;

  localparam logic [31:0] K_0 = 32'h5a827999;
  localparam logic [31:0] K_1 = 32'h6ed9eba1;
  localparam logic [31:0] K_2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_3 = 32'hca62c1d6;

  localparam logic [HASH_WORDS-1:0][31:0] H_INIT = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic OP_APPEND   = 1'b0;
  localparam logic OP_FINALIZE = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] message_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        empty_message;
  } out_item_t;

  // Controls from the sequencer to the compression unit.
  typedef struct packed {
    logic push;   // shift a new word into the block window
    logic init;   // reload the initial hash
    logic start;  // begin 80 rounds on the window
  } core_ctrl_t;

endpackage

>>> rtl/sha1_byte_stream_digest.sv
// Top level of the byte-stream SHA-1 digest engine: byte packing, padding and output.
//
// Input channel (in_valid/in_ready/in_data): each transfer carries an opcode and a
// byte. An append packs the byte big-endian into the current 64-byte block; a
// finalize pads the message (0x80, zeros, 64-bit bit length) and emits the digest.
// Output channel (out_valid/out_ready/out_data): a finalize yields five transfers,
// H0 first, word_index 0..4, last_word on the fifth. An empty message gives five
// all-zero words with empty_message set. A second finalize re-emits the same digest; a
// byte after a finalize starts a new message from the initial hash.
// Sequence: an append that completes a block starts the 80 rounds and the hash
// add in the shared round unit. A finalize loads the padding words, then runs the
// rounds; a second block of padding and length follows when 56 or more bytes are
// held; then the digest words are output. A repeated finalize or an empty message
// goes straight to the output words.
// in_ready is high only while the sequencer is idle, so one item is in work at
// a time. A stalled receiver holds the current digest word; nothing is lost.
// Reset (rst_n low, synchronous) restores the initial hash and clears all counts.
module sha1_byte_stream_digest
  import sha1bsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PAD  = 4'b0010,
    ST_COMP = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [5:0]           buf_cnt_r, buf_cnt_nxt;
  logic [23:0]          acc_r, acc_nxt;
  logic [COUNT_W-1:0]   total_r, total_nxt;
  logic                 fin_r, fin_nxt;
  logic [3:0]           wcnt_r, wcnt_nxt;
  logic                 pad_first_r, pad_first_nxt;
  logic                 len_ok_r, len_ok_nxt;
  logic                 in_fin_r, in_fin_nxt;
  logic [2:0]           out_idx_r, out_idx_nxt;

  core_ctrl_t                  ctrl;
  logic [31:0]                 push_word;
  logic                        core_done;
  logic [HASH_WORDS-1:0][31:0] hash;

  logic        in_xfer;
  logic        total_zero;
  logic [5:0]  pos_eff;
  logic [COUNT_W-1:0] total_base;
  logic [31:0] pad_word;
  logic [31:0] len_hi;
  logic [31:0] len_lo;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign out_valid  = (state_r == ST_OUT);
  assign total_zero = (total_r == '0);
  assign len_hi     = total_r[60:29];
  assign len_lo     = {total_r[28:0], 3'b000};

  always_comb begin
    case (buf_cnt_r[1:0])
      2'd0:    pad_word = {PAD_BYTE, 24'h0};
      2'd1:    pad_word = {acc_r[23:16], PAD_BYTE, 16'h0};
      2'd2:    pad_word = {acc_r[23:8], PAD_BYTE, 8'h0};
      default: pad_word = {acc_r, PAD_BYTE};
    endcase
  end

  always_comb begin
    out_data.digest_word   = total_zero ? '0 : hash[out_idx_r];
    out_data.word_index    = out_idx_r;
    out_data.last_word     = (out_idx_r == 3'd4);
    out_data.empty_message = total_zero;
  end

  always_comb begin
    state_nxt     = state_r;
    buf_cnt_nxt   = buf_cnt_r;
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    fin_nxt       = fin_r;
    wcnt_nxt      = wcnt_r;
    pad_first_nxt = pad_first_r;
    len_ok_nxt    = len_ok_r;
    in_fin_nxt    = in_fin_r;
    out_idx_nxt   = out_idx_r;
    ctrl          = '0;
    push_word     = '0;
    pos_eff       = fin_r ? 6'd0 : buf_cnt_r;
    total_base    = fin_r ? '0 : total_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.opcode == OP_APPEND) begin
            ctrl.init = fin_r;
            fin_nxt   = 1'b0;
            total_nxt = (&total_base) ? total_base : total_base + 1'b1;
            case (pos_eff[1:0])
              2'd0:    acc_nxt[23:16] = in_data.message_byte;
              2'd1:    acc_nxt[15:8]  = in_data.message_byte;
              2'd2:    acc_nxt[7:0]   = in_data.message_byte;
              default: begin
                ctrl.push = 1'b1;
                push_word = {acc_r, in_data.message_byte};
              end
            endcase
            buf_cnt_nxt = pos_eff + 6'd1;
            if (pos_eff == 6'd63) begin
              ctrl.start = 1'b1;
              in_fin_nxt = 1'b0;
              state_nxt  = ST_COMP;
            end
          end else begin
            fin_nxt = 1'b1;
            if (fin_r || total_zero) begin
              out_idx_nxt = '0;
              state_nxt   = ST_OUT;
            end else begin
              wcnt_nxt      = buf_cnt_r[5:2];
              pad_first_nxt = 1'b1;
              len_ok_nxt    = (buf_cnt_r < 6'd56);
              in_fin_nxt    = 1'b1;
              state_nxt     = ST_PAD;
            end
          end
        end
      end

      ST_PAD: begin
        ctrl.push = 1'b1;
        if (pad_first_r) begin
          push_word = pad_word;
        end else if (len_ok_r && wcnt_r == 4'd14) begin
          push_word = len_hi;
        end else if (len_ok_r && wcnt_r == 4'd15) begin
          push_word = len_lo;
        end else begin
          push_word = '0;
        end
        pad_first_nxt = 1'b0;
        wcnt_nxt      = wcnt_r + 4'd1;
        if (wcnt_r == 4'd15) begin
          ctrl.start = 1'b1;
          state_nxt  = ST_COMP;
        end
      end

      ST_COMP: begin
        if (core_done) begin
          if (!in_fin_r) begin
            state_nxt = ST_IDLE;
          end else if (!len_ok_r) begin
            // length did not fit: one more all-padding block
            len_ok_nxt = 1'b1;
            state_nxt  = ST_PAD;
          end else begin
            in_fin_nxt  = 1'b0;
            buf_cnt_nxt = '0;
            out_idx_nxt = '0;
            state_nxt   = ST_OUT;
          end
        end
      end

      ST_OUT: begin
        if (out_ready) begin
          if (out_idx_r == 3'd4) begin
            out_idx_nxt = '0;
            state_nxt   = ST_IDLE;
          end else begin
            out_idx_nxt = out_idx_r + 3'd1;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      buf_cnt_r   <= '0;
      total_r     <= '0;
      fin_r       <= 1'b0;
      wcnt_r      <= '0;
      pad_first_r <= 1'b0;
      len_ok_r    <= 1'b0;
      in_fin_r    <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      buf_cnt_r   <= buf_cnt_nxt;
      total_r     <= total_nxt;
      fin_r       <= fin_nxt;
      wcnt_r      <= wcnt_nxt;
      pad_first_r <= pad_first_nxt;
      len_ok_r    <= len_ok_nxt;
      in_fin_r    <= in_fin_nxt;
      out_idx_r   <= out_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  sha1bsd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .push_word (push_word),
    .done      (core_done),
    .hash      (hash)
  );

endmodule

>>> rtl/sha1bsd_core.sv
// SHA-1 compression unit: one round per cycle over a 16-word schedule window.
module sha1bsd_core
  import sha1bsd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  core_ctrl_t                   ctrl,
  input  logic [31:0]                  push_word,
  output logic                         done,
  output logic [HASH_WORDS-1:0][31:0]  hash
);

  logic [31:0] win_r [BLOCK_WORDS];
  logic [HASH_WORDS-1:0][31:0] h_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [6:0]  rnd_r;
  logic        run_r;

  logic [31:0] sched_x;
  logic [31:0] sched;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;
  logic        rounding;

  assign rounding = run_r && (rnd_r <= ROUND_LAST);
  assign done     = run_r && (rnd_r == ROUND_ADD);
  assign hash     = h_r;

  assign sched_x = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign sched   = {sched_x[30:0], sched_x[31]};

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = d_r ^ (b_r & (c_r ^ d_r));
      k = K_0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = K_1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (d_r & (b_r | c_r));
      k = K_2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K_3;
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + win_r[0];
  end

  // Window: newest word at the top; the round always consumes entry 0.
  always_ff @(posedge clk) begin
    if (ctrl.push || rounding) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[BLOCK_WORDS-1] <= ctrl.push ? push_word : sched;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (rounding) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r   <= H_INIT;
      run_r <= 1'b0;
      rnd_r <= '0;
    end else begin
      if (ctrl.init) begin
        h_r <= H_INIT;
      end else if (done) begin
        h_r[0] <= h_r[0] + a_r;
        h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r;
        h_r[4] <= h_r[4] + e_r;
      end
      if (ctrl.start) begin
        run_r <= 1'b1;
        rnd_r <= '0;
      end else if (done) begin
        run_r <= 1'b0;
      end else if (run_r) begin
        rnd_r <= rnd_r + 7'd1;
      end
    end
  end

endmodule

>>> test/sha1_byte_stream_digest_tb.sv
// Self-checking testbench for the byte-stream SHA-1 digest engine.
`timescale 1ns / 1ps

module sha1_byte_stream_digest_tb;
  import sha1bsd_pkg::*;

  typedef struct packed {
    logic             opcode;
    logic [7:0]       message_byte;
    logic             typed;         // expectation written out below, not predicted
    logic             typed_empty;
    logic [4:0][31:0] typed_digest;
  } dir_row_t;

  localparam logic [4:0][31:0] ABC_DIGEST = {
    32'h9cd0d89d, 32'h7850c26c, 32'hba3e2571, 32'h4706816a, 32'ha9993e36
  };
  localparam logic [4:0][31:0] SEED_HASH = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };
  localparam logic [60:0] COUNT_MAX = '1;

  localparam int N_DIR = 25;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{OP_FINALIZE, 8'h00, 1'b1, 1'b1, '0},          // empty message after reset
    '{OP_FINALIZE, 8'h00, 1'b1, 1'b1, '0},          // repeat on empty
    '{OP_APPEND,   8'h61, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'h62, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'h63, 1'b0, 1'b0, '0},
    '{OP_FINALIZE, 8'h00, 1'b1, 1'b0, ABC_DIGEST},  // "abc"
    '{OP_FINALIZE, 8'hff, 1'b1, 1'b0, ABC_DIGEST},  // repeat re-emits
    '{OP_APPEND,   8'h00, 1'b0, 1'b0, '0},          // restarts the message
    '{OP_APPEND,   8'hff, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'h80, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'h7f, 1'b0, 1'b0, '0},
    '{OP_FINALIZE, 8'h00, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'h55, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'haa, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'h01, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'hfe, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'h80, 1'b0, 1'b0, '0},
    '{OP_FINALIZE, 8'h00, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'hff, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'hff, 1'b0, 1'b0, '0},
    '{OP_FINALIZE, 8'hff, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'h00, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'h00, 1'b0, 1'b0, '0},
    '{OP_APPEND,   8'h00, 1'b0, 1'b0, '0},
    '{OP_FINALIZE, 8'h00, 1'b0, 1'b0, '0}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // predictor state
  logic [31:0]       hash_state [5];
  logic [15:0][31:0] msg_block;
  int unsigned       held_bytes;
  logic [60:0]       byte_count;
  logic              digest_done;

  out_item_t pending_digest_words [$];
  int        fail_count = 0;
  logic      calm = 1'b0;

  sha1_byte_stream_digest u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  initial begin
    #10_000_000;
    $display("sha1_byte_stream_digest test failed");
    $finish;
  end

  function automatic void restart_hash();
    for (int i = 0; i < 5; i++) hash_state[i] = SEED_HASH[i];
    held_bytes  = 0;
    byte_count  = '0;
    digest_done = 1'b0;
  endfunction

  function automatic void compress_block(input logic [15:0][31:0] blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 80; i++) begin
      t    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {t[30:0], t[31]};
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = d ^ (b & (c ^ d));
        k = 32'h5a827999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ed9eba1;
      end else if (i < 60) begin
        f = (b & c) | (d & (b | c));
        k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d;
        k = 32'hca62c1d6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] data);
    int unsigned lane, idx;
    if (digest_done) restart_hash();
    lane = held_bytes % 4;
    idx  = held_bytes / 4;
    if (lane == 0) msg_block[idx] = {data, 24'h0};
    else           msg_block[idx] |= 32'(data) << (24 - 8 * lane);
    if (byte_count != COUNT_MAX) byte_count++;
    if (held_bytes == 63) begin
      compress_block(msg_block);
      held_bytes = 0;
    end else begin
      held_bytes++;
    end
  endfunction

  function automatic void close_message();
    logic [15:0][31:0] blk;
    logic [63:0]       bit_len;
    int unsigned       lane, idx;
    digest_done = 1'b1;
    if (byte_count == 0) return;
    blk     = msg_block;
    lane    = held_bytes % 4;
    idx     = held_bytes / 4;
    bit_len = {byte_count, 3'b000};
    if (lane == 0) blk[idx] = 32'h8000_0000;
    else blk[idx] = (blk[idx] & (32'hffff_ffff << (32 - 8 * lane))) |
                    (32'h80 << (24 - 8 * lane));
    for (int i = idx + 1; i < 16; i++) blk[i] = '0;
    // no room for the length: it goes into an extra block
    if (held_bytes >= 56) begin
      compress_block(blk);
      blk = '0;
    end
    blk[14] = bit_len[63:32];
    blk[15] = bit_len[31:0];
    compress_block(blk);
    held_bytes = 0;
  endfunction

  function automatic void queue_digest(input logic typed, input logic typed_empty,
                                       input logic [4:0][31:0] typed_digest);
    out_item_t word;
    logic      empty;
    empty = (byte_count == 0);
    for (int i = 0; i < 5; i++) begin
      word.digest_word   = typed ? typed_digest[i] : (empty ? 32'h0 : hash_state[i]);
      word.word_index    = 3'(i);
      word.last_word     = (i == 4);
      word.empty_message = typed ? typed_empty : empty;
      pending_digest_words.push_back(word);
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input in_item_t item, input logic typed, input logic typed_empty,
                           input logic [4:0][31:0] typed_digest);
    if (!calm && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (item.opcode == OP_APPEND) begin
      absorb_byte(item.message_byte);
    end else begin
      if (!digest_done) close_message();
      queue_digest(typed, typed_empty, typed_digest);
    end
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len);
    in_item_t item;
    for (int i = 0; i < len; i++) begin
      item.opcode       = OP_APPEND;
      item.message_byte = 8'($urandom_range(0, 255));
      send_item(item, 1'b0, 1'b0, '0);
    end
    item.opcode       = OP_FINALIZE;
    item.message_byte = 8'($urandom_range(0, 255));
    send_item(item, 1'b0, 1'b0, '0);
    // occasional repeated finalize
    if ($urandom_range(0, 3) == 0) send_item(item, 1'b0, 1'b0, '0);
  endtask

  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_digest_words.size() == 0) begin
        $error("unexpected digest word transfer: %h", out_data.digest_word);
        fail_count++;
      end else begin
        want = pending_digest_words.pop_front();
        if (out_data.digest_word !== want.digest_word) begin
          $error("digest_word expected %h got %h", want.digest_word, out_data.digest_word);
          fail_count++;
        end
        if (out_data.word_index !== want.word_index) begin
          $error("word_index expected %0d got %0d", want.word_index, out_data.word_index);
          fail_count++;
        end
        if (out_data.last_word !== want.last_word) begin
          $error("last_word expected %b got %b", want.last_word, out_data.last_word);
          fail_count++;
        end
        if (out_data.empty_message !== want.empty_message) begin
          $error("empty_message expected %b got %b", want.empty_message,
                 out_data.empty_message);
          fail_count++;
        end
      end
    end
  end

  initial begin
    in_item_t item;
    int unsigned edge_len [2] = '{56, 64};
    msg_block = '0;
    restart_hash();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIR; r++) begin
      item.opcode       = DIRECTED[r].opcode;
      item.message_byte = DIRECTED[r].message_byte;
      send_item(item, DIRECTED[r].typed, DIRECTED[r].typed_empty,
                DIRECTED[r].typed_digest);
    end

    // padding boundaries: length spills into an extra block, exact full block
    for (int m = 0; m < 2; m++) begin
      calm = (m >= 1);
      send_message(edge_len[m]);
    end
    calm = 1'b0;
    for (int m = 0; m < 2; m++) send_message($urandom_range(1, 6));

    in_valid <= 1'b0;
    while (pending_digest_words.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (fail_count == 0)
      $display("sha1_byte_stream_digest test passed");
    else
      $display("sha1_byte_stream_digest test failed");
    $finish;
  end

endmodule
